FILE: src/lfsf_pkg.sv
// lfsf_pkg: shared constants, register codes and types for the line and
// field splitter with substring filter
// no dependencies
package lfsf_pkg;

  // sizing of the block
  localparam int MAX_FIELDS  = 64;
  localparam int LINE_BYTES  = 4096;
  localparam int PATTERN_MAX = 16;

  // field widths fixed by the interface
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 5;
  localparam int FIELD_W   = 7;
  localparam int LINE_W    = 12;
  localparam int LNUM_W    = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 64;
  localparam int PAT_BYTES = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_DELIM     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH    = 8'd3;

  // character codes
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

  // delimiter value that selects whitespace splitting
  localparam logic [BYTE_W-1:0] DELIM_WS = CH_SPACE;

  // decoded configuration seen by the datapath
  typedef struct packed {
    logic [BYTE_W-1:0]                 delim;
    logic [LEN_W-1:0]                  eff_len;
    logic [PAT_BYTES-1:0]              mask;
    logic [PAT_BYTES-1:0]              top;
    logic [PAT_BYTES-1:0][BYTE_W-1:0]  pat;
  } pat_cfg_t;

endpackage

FILE: src/lfsf_cfg.sv
// lfsf_cfg: configuration registers and decode of the effective pattern
// depends on lfsf_pkg
module lfsf_cfg import lfsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output pat_cfg_t             pcfg
);

  logic [BYTE_W-1:0] field_delimiter;
  logic [LEN_W-1:0]  pattern_length;
  logic [CFG_W-1:0]  pattern_low_bytes;
  logic [CFG_W-1:0]  pattern_high_bytes;

  logic [LEN_W-1:0]                 lim;
  logic [LEN_W-1:0]                 eff;
  logic [PAT_BYTES-1:0][BYTE_W-1:0] pat;
  logic [PAT_BYTES:0]               mask_wide;
  logic [PAT_BYTES-1:0]             mask;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_delimiter    <= DELIM_WS;
      pattern_length     <= '0;
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIELD_DELIM:    field_delimiter    <= cfg_data[BYTE_W-1:0];
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[LEN_W-1:0];
        REG_PATTERN_LOW:    pattern_low_bytes  <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pat = {pattern_high_bytes, pattern_low_bytes};

  // effective length: first slash or zero byte below the length limit
  always_comb begin
    lim = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pattern_length;
    if (lim > LEN_W'(PAT_BYTES)) lim = LEN_W'(PAT_BYTES);
    eff = lim;
    for (int i = PAT_BYTES - 1; i >= 0; i--) begin
      if ((pat[i] == CH_NUL || pat[i] == CH_SLASH) && (LEN_W'(i) < lim)) begin
        eff = LEN_W'(i);
      end
    end
  end

  // match bit mask and the bit that signals a full match
  assign mask_wide = ((PAT_BYTES+1)'(1) << eff) - (PAT_BYTES+1)'(1);
  assign mask      = mask_wide[PAT_BYTES-1:0];

  assign pcfg.delim   = field_delimiter;
  assign pcfg.eff_len = eff;
  assign pcfg.mask    = mask;
  assign pcfg.top     = mask & ~(mask >> 1);
  assign pcfg.pat     = pat;

endmodule

FILE: src/lfsf_core.sv
// lfsf_core: per-byte line state, field splitting, shift-and matching and
// the result register
// depends on lfsf_pkg
module lfsf_core import lfsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               core_ready,
  input  logic [BYTE_W-1:0]  byte_in,
  input  pat_cfg_t           pcfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] field_number,
  output logic               line_end,
  output logic [LNUM_W-1:0]  line_number,
  output logic [FIELD_W-1:0] field_count,
  output logic               line_matched,
  output logic [LINE_W-1:0]  line_length
);

  // line state
  logic [PAT_BYTES-1:0] pm;
  logic                 match_found;
  logic [LINE_W-1:0]    bytes_in_line;
  logic [LNUM_W-1:0]    lines_seen;
  logic [FIELD_W-1:0]   fields_seen;
  logic                 inside_field;
  logic                 zero_seen;

  logic [PAT_BYTES-1:0] pm_next;
  logic                 match_found_next;
  logic [LINE_W-1:0]    bytes_in_line_next;
  logic [LNUM_W-1:0]    lines_seen_next;
  logic [FIELD_W-1:0]   fields_seen_next;
  logic                 inside_field_next;
  logic                 zero_seen_next;

  logic                 step;
  logic                 close;
  logic                 sep;
  logic [PAT_BYTES-1:0] pm_m;
  logic [PAT_BYTES-1:0] hit;
  logic [FIELD_W-1:0]   fnum;
  logic                 matched;

  assign core_ready = !out_valid || out_ready;
  assign step       = byte_valid && core_ready;

  assign close = (byte_in == CH_NL) || (bytes_in_line >= LINE_W'(LINE_BYTES - 1));
  assign pm_m  = pm & pcfg.mask;

  // separator test for the current delimiter
  always_comb begin
    if (pcfg.delim == DELIM_WS) begin
      sep = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
    end else if (pcfg.delim == CH_NUL) begin
      sep = 1'b0;
    end else begin
      sep = (byte_in == pcfg.delim);
    end
  end

  // pattern positions equal to this byte
  always_comb begin
    for (int i = 0; i < PAT_BYTES; i++) begin
      hit[i] = (pcfg.pat[i] == byte_in);
    end
  end

  // next line state and result fields
  always_comb begin
    pm_next            = pm_m;
    match_found_next   = match_found;
    bytes_in_line_next = bytes_in_line;
    lines_seen_next    = lines_seen;
    fields_seen_next   = fields_seen;
    inside_field_next  = inside_field;
    zero_seen_next     = zero_seen;
    fnum               = '0;
    matched            = 1'b0;
    if (close) begin
      lines_seen_next    = lines_seen + LNUM_W'(1);
      matched            = (pcfg.eff_len == '0) || match_found;
      pm_next            = '0;
      match_found_next   = 1'b0;
      bytes_in_line_next = '0;
      fields_seen_next   = '0;
      inside_field_next  = 1'b0;
      zero_seen_next     = 1'b0;
    end else begin
      bytes_in_line_next = bytes_in_line + LINE_W'(1);
      zero_seen_next     = zero_seen || (byte_in == CH_NUL);
      if (!zero_seen_next) begin
        if (sep) begin
          inside_field_next = 1'b0;
        end else if (inside_field) begin
          fnum = fields_seen;
        end else if (fields_seen < FIELD_W'(MAX_FIELDS)) begin
          fields_seen_next  = fields_seen + FIELD_W'(1);
          inside_field_next = 1'b1;
          fnum              = fields_seen + FIELD_W'(1);
        end
        pm_next          = ((pm_m << 1) | PAT_BYTES'(1)) & hit & pcfg.mask;
        match_found_next = match_found || (|(pm_next & pcfg.top));
      end
      matched = (pcfg.eff_len == '0) || match_found_next;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pm            <= '0;
      match_found   <= 1'b0;
      bytes_in_line <= '0;
      lines_seen    <= '0;
      fields_seen   <= '0;
      inside_field  <= 1'b0;
      zero_seen     <= 1'b0;
    end else if (step) begin
      pm            <= pm_next;
      match_found   <= match_found_next;
      bytes_in_line <= bytes_in_line_next;
      lines_seen    <= lines_seen_next;
      fields_seen   <= fields_seen_next;
      inside_field  <= inside_field_next;
      zero_seen     <= zero_seen_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload; a closed line reports its own field count
  always_ff @(posedge clk) begin
    if (step) begin
      field_number <= fnum;
      line_end     <= close;
      line_number  <= lines_seen_next;
      field_count  <= close ? fields_seen : fields_seen_next;
      line_matched <= matched;
      line_length  <= bytes_in_line;
    end
  end

  // a line-closing transaction belongs to no field
  assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> field_number == '0)
    else $error("line close reported a field number");

  // a byte never belongs to a field beyond the count
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> field_number <= field_count)
    else $error("field number above field count");

  // closing a line clears the line state
  assert property (@(posedge clk) disable iff (rst)
    step && close |=> bytes_in_line == '0 && fields_seen == '0 && !inside_field)
    else $error("line state not cleared at line close");

  // a stored byte advances the line length by one
  assert property (@(posedge clk) disable iff (rst)
    step && !close |=> bytes_in_line == $past(bytes_in_line) + LINE_W'(1))
    else $error("line length did not advance");

  // field count stays within the cap
  assert property (@(posedge clk) disable iff (rst)
    fields_seen <= FIELD_W'(MAX_FIELDS))
    else $error("field count above cap");

endmodule

FILE: src/line_field_splitter_filter.sv
// line_field_splitter_filter: top level with the input register
// depends on lfsf_pkg, lfsf_cfg and lfsf_core
//
// Usage:
// - input channel in_valid/in_ready/in_byte carries one text byte per
//   transaction; output channel out_valid/out_ready carries one result per
//   byte: field number, line end flag, line number, field count, match flag
//   and line length before the byte
// - configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
//   delimiter (0), pattern length (1), pattern bytes 0-7 (2) and 8-15 (3);
//   cfg_ready is always high, writes belong only in idle periods
// - a byte is held in the input register and its result is then loaded into
//   the result register, where it stays until out_ready takes it
// - throughput is one byte per cycle while out_ready stays high; the single
//   per-byte state update in lfsf_core sets it
// - when the receiver stalls the result register holds, the input register
//   fills and then in_ready drops until out_ready returns
// - synchronous reset clears the line state, counters and both valid
//   flags, and restores delimiter 32 (space/tab) and an empty pattern
module line_field_splitter_filter import lfsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FIELD_W-1:0]   field_number,
  output logic                 line_end,
  output logic [LNUM_W-1:0]    line_number,
  output logic [FIELD_W-1:0]   field_count,
  output logic                 line_matched,
  output logic [LINE_W-1:0]    line_length,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic              s_valid;
  logic [BYTE_W-1:0] s_byte;
  logic              core_ready;
  pat_cfg_t          pcfg;

  assign in_ready = !s_valid || core_ready;

  // input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte <= in_byte;
    end
  end

  lfsf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pcfg      (pcfg)
  );

  lfsf_core u_core (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (s_valid),
    .core_ready   (core_ready),
    .byte_in      (s_byte),
    .pcfg         (pcfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .field_number (field_number),
    .line_end     (line_end),
    .line_number  (line_number),
    .field_count  (field_count),
    .line_matched (line_matched),
    .line_length  (line_length)
  );

endmodule

FILE: tb/sv/lfsf_checker.sv
// lfsf_checker: watches the byte, result and register channels of the line
// and field splitter, predicts every result and compares it field by field
// depends on lfsf_pkg
module lfsf_checker import lfsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [FIELD_W-1:0]   field_number,
  input  logic                 line_end,
  input  logic [LNUM_W-1:0]    line_number,
  input  logic [FIELD_W-1:0]   field_count,
  input  logic                 line_matched,
  input  logic [LINE_W-1:0]    line_length,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   outstanding
);

  // one result transaction
  typedef struct packed {
    logic [FIELD_W-1:0] fnum;
    logic               lend;
    logic [LNUM_W-1:0]  lnum;
    logic [FIELD_W-1:0] fcnt;
    logic               matched;
    logic [LINE_W-1:0]  llen;
  } split_result_t;

  // register copy
  logic [BYTE_W-1:0]     delim;
  logic [LEN_W-1:0]      pat_len;
  logic [2*CFG_W-1:0]    pat_bytes;

  // line state copy
  logic [PAT_BYTES-1:0]  match_bits;
  bit                    found;
  int                    line_bytes;
  logic [LNUM_W-1:0]     lines_done;
  int                    fields_found;
  bit                    in_field;
  bit                    nul_seen;

  split_result_t pending_results[$];

  // effective pattern length: stops at slash or zero byte
  function automatic int pattern_span();
    int lim;
    int i;
    logic [BYTE_W-1:0] b;
    lim = pat_len;
    if (lim > PATTERN_MAX) lim = PATTERN_MAX;
    if (lim > PAT_BYTES) lim = PAT_BYTES;
    for (i = 0; i < lim; i++) begin
      b = pat_bytes[8*i +: 8];
      if (b == CH_NUL || b == CH_SLASH) return i;
    end
    return lim;
  endfunction

  function automatic bit is_separator(input logic [BYTE_W-1:0] c);
    if (delim == DELIM_WS) return c == CH_SPACE || c == CH_TAB;
    if (delim == CH_NUL) return 1'b0;
    return c == delim;
  endfunction

  // advance the line state by one byte and return its result
  function automatic split_result_t split_byte(input logic [BYTE_W-1:0] c);
    int plen;
    int i;
    logic [PAT_BYTES-1:0] keep;
    logic [PAT_BYTES-1:0] hit;
    split_result_t r;
    plen = pattern_span();
    keep = (plen == 0) ? '0 : PAT_BYTES'((32'd1 << plen) - 32'd1);
    match_bits &= keep;
    r = '0;
    r.llen = LINE_W'(line_bytes);
    // newline or full line closes the line, the byte itself is dropped
    if (c == CH_NL || line_bytes >= LINE_BYTES - 1) begin
      lines_done = lines_done + 1'b1;
      r.lend = 1'b1;
      r.lnum = lines_done;
      r.fcnt = FIELD_W'(fields_found);
      r.matched = (plen == 0) || found;
      match_bits = '0;
      found = 1'b0;
      line_bytes = 0;
      fields_found = 0;
      in_field = 1'b0;
      nul_seen = 1'b0;
      return r;
    end
    line_bytes++;
    if (c == CH_NUL) nul_seen = 1'b1;
    // content after a zero byte is neither split nor searched
    if (!nul_seen) begin
      if (is_separator(c)) begin
        in_field = 1'b0;
      end else if (in_field) begin
        r.fnum = FIELD_W'(fields_found);
      end else if (fields_found < MAX_FIELDS) begin
        fields_found++;
        in_field = 1'b1;
        r.fnum = FIELD_W'(fields_found);
      end
      hit = '0;
      for (i = 0; i < plen; i++)
        if (pat_bytes[8*i +: 8] == c) hit[i] = 1'b1;
      if (plen != 0) begin
        match_bits = ((match_bits << 1) | 1'b1) & hit & keep;
        if (match_bits[plen-1]) found = 1'b1;
      end
    end
    r.lnum = lines_done;
    r.fcnt = FIELD_W'(fields_found);
    r.matched = (plen == 0) || found;
    return r;
  endfunction

  task automatic compare_field(input string name, input longint unsigned want,
                               input logic [LNUM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // follow every transaction on the three channels
  always @(posedge clk) begin
    split_result_t want;
    if (rst) begin
      delim = DELIM_WS;
      pat_len = '0;
      pat_bytes = '0;
      match_bits = '0;
      found = 1'b0;
      line_bytes = 0;
      lines_done = '0;
      fields_found = 0;
      in_field = 1'b0;
      nul_seen = 1'b0;
      fail_count = 0;
      pending_results.delete();
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIELD_DELIM:    delim = cfg_data[BYTE_W-1:0];
          REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          REG_PATTERN_LOW:    pat_bytes[CFG_W-1:0] = cfg_data;
          REG_PATTERN_HIGH:   pat_bytes[2*CFG_W-1:CFG_W] = cfg_data;
          default: ;
        endcase
      end
      // byte accepted: predict its result
      if (in_valid && in_ready) pending_results.push_back(split_byte(in_byte));
      // result accepted: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no prediction pending");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("field_number", want.fnum, field_number);
          compare_field("line_end", want.lend, line_end);
          compare_field("line_number", want.lnum, line_number);
          compare_field("field_count", want.fcnt, field_count);
          compare_field("line_matched", want.matched, line_matched);
          compare_field("line_length", want.llen, line_length);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/sv/line_field_splitter_filter_tb.sv
// line_field_splitter_filter_tb: stimulus and verdict for the line and field
// splitter; depends on lfsf_pkg, line_field_splitter_filter and lfsf_checker
module line_field_splitter_filter_tb;
  import lfsf_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int IDLE_PCT     = 18;
  localparam int LONG_HOLD    = 80;
  localparam int PHASE_BYTES  = 70;
  localparam int RAND_PHASES  = 7;
  localparam int SETTLE       = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FIELD_W-1:0]   field_number;
  logic                 line_end;
  logic [LNUM_W-1:0]    line_number;
  logic [FIELD_W-1:0]   field_count;
  logic                 line_matched;
  logic [LINE_W-1:0]    line_length;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FIELD_DELIM;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int sent = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  // current setting, used to shape the text
  logic [BYTE_W-1:0]  delim_now = DELIM_WS;
  logic [2*CFG_W-1:0] pat_now = '0;
  int                 pat_len_now = 0;
  logic [BYTE_W-1:0]  alpha [4] = '{"a", "b", "c", "x"};

  line_field_splitter_filter u_top (.*);

  lfsf_checker u_checker (.*);

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic logic [CFG_W-1:0] pack8(input string s);
    logic [CFG_W-1:0] r;
    int i;
    r = '0;
    for (i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  // one byte transaction, then maybe a gap
  task automatic put_byte(input logic [BYTE_W-1:0] b);
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
    end
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // stop sending and wait until every predicted result has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  // write all four registers; unused upper bits carry noise
  task automatic set_regs(input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len,
                          input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    write_reg(REG_FIELD_DELIM, {56'({$urandom, $urandom}), d}, 1'b0);
    write_reg(REG_PATTERN_LENGTH, {59'({$urandom, $urandom}), len}, 1'b0);
    write_reg(REG_PATTERN_LOW, lo, 1'b0);
    write_reg(REG_PATTERN_HIGH, hi, 1'b1);
    delim_now = d;
    pat_now = {hi, lo};
    pat_len_now = (len > PAT_BYTES) ? PAT_BYTES : len;
  endtask

  function automatic logic [BYTE_W-1:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return alpha[$urandom_range(0, 3)];
    if (r < 55) return delim_now;
    if (r < 65) return CH_SPACE;
    if (r < 70) return CH_TAB;
    if (r < 72) return CH_NUL;
    if (r < 75) return CH_NL;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // mostly text lines, some with the pattern planted, some noise and open lines
  task automatic random_line();
    int n;
    int plant;
    int i;
    int j;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 20);
      for (i = 0; i < n; i++) put_byte(BYTE_W'($urandom_range(0, 255)));
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200) : $urandom_range(0, 24);
      plant = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n) : -1;
      for (i = 0; i <= n; i++) begin
        if (i == plant)
          for (j = 0; j < pat_len_now; j++) put_byte(pat_now[8*j +: 8]);
        if (i < n) put_byte(text_byte());
      end
      if ($urandom_range(0, 9) != 0) put_byte(CH_NL);
    end
  endtask

  // new random setting per phase, extremes in the first ones
  task automatic random_setting(input int k);
    logic [BYTE_W-1:0] d;
    logic [LEN_W-1:0] len;
    logic [2*CFG_W-1:0] p;
    int i;
    int r;
    case ($urandom_range(0, 7))
      0: d = DELIM_WS;
      1: d = ",";
      2: d = CH_NUL;
      3: d = 8'hFF;
      4: d = CH_NL;
      5: d = CH_TAB;
      6: d = alpha[$urandom_range(0, 3)];
      default: d = BYTE_W'($urandom_range(0, 255));
    endcase
    case (k)
      0: len = '0;
      1: len = '1;
      2: len = LEN_W'(PAT_BYTES);
      default: len = LEN_W'($urandom_range(1, 6));
    endcase
    for (i = 0; i < PAT_BYTES; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) p[8*i +: 8] = CH_SLASH;
      else if (r < 7) p[8*i +: 8] = CH_NUL;
      else p[8*i +: 8] = alpha[$urandom_range(0, 3)];
    end
    if (k == 5) p = {$urandom, $urandom, $urandom, $urandom};
    set_regs(d, len, p[CFG_W-1:0], p[2*CFG_W-1:CFG_W]);
  endtask

  // stimulus and verdict
  initial begin
    int i;
    int start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset setting: whitespace split, empty pattern matches all
    put_text("\n");
    put_byte(8'hFF);
    put_text(" \ta");
    put_byte(CH_NUL);
    put_text("b \n");
    wait_for_results();

    // comma split, pattern cut short at the slash
    set_regs(",", 5'd5, pack8("ab/c"), {$urandom, $urandom});
    put_text("x,,ab\t\n");
    wait_for_results();

    // zero delimiter, full 16-byte pattern with length above the maximum
    set_regs(CH_NUL, '1, pack8("abcdefgh"), pack8("ijklmnop"));
    put_text("a b,abcdefghijklmnop");
    put_byte(CH_NUL);
    put_text("q\n");
    wait_for_results();

    // newline delimiter, pattern cut at a zero byte
    set_regs(CH_NL, 5'd3, pack8("z"), '1);
    put_text("zz z\n");
    wait_for_results();

    // all-ones delimiter and pattern
    set_regs(8'hFF, 5'd2, '1, '0);
    put_byte(8'hFF);
    put_text("a");
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_text("b\n");
    wait_for_results();

    // write to an index with no register behind it
    write_reg(REG_UNUSED, {$urandom, $urandom}, 1'b1);

    // register change in the middle of a line
    set_regs(CH_TAB, 5'd2, pack8("ab"), '0);
    put_text("zza");
    wait_for_results();
    set_regs(DELIM_WS, 5'd3, pack8("abc"), '0);
    put_text("bc d\n");

    // more fields than the cap
    for (i = 0; i < MAX_FIELDS + 6; i++) put_text("f ");
    put_byte(CH_NL);
    wait_for_results();

    // random phases
    for (i = 0; i < RAND_PHASES; i++) begin
      random_setting(i);
      quiet <= (i == 2);
      if (i == 4) hold_request <= 1'b1;
      start = sent;
      while (sent - start < PHASE_BYTES) random_line();
      wait_for_results();
    end

    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
